FILE: rtl/core/plcbp_pkg.sv
// ----------------------------------------------------------------------------
// plcbp_pkg - shared types and constants of the playlist byte parser
// Field kinds, status codes, signature bytes and beat payload structs.
// ----------------------------------------------------------------------------
package plcbp_pkg;

   // Default width of the saturating entry counter
   localparam int unsigned ENTRY_COUNT_BITS_DEF = 32;

   // Width of the byte position and length registers
   localparam int unsigned FIELD_CNT_W = 16;

   // Result field widths
   localparam int unsigned KIND_W   = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ENTRY_W  = 32;
   localparam int unsigned STATUS_W = 3;

   // Fixed field lengths in bytes
   localparam int unsigned MAGIC_LEN      = 8;
   localparam int unsigned TAG_LEN        = 4;
   localparam int unsigned COUNT_LEN_WIDE = 4;
   localparam int unsigned COUNT_LEN_NARR = 2;
   localparam int unsigned TIME_LEN       = 8;

   // Parse phase, which is also the field kind shown on the result
   typedef enum logic [KIND_W-1:0] {
      PH_MAGIC   = 4'd0,
      PH_INFOTAG = 4'd1,
      PH_FEAT    = 4'd2,
      PH_MAKLEN  = 4'd3,
      PH_MAKCH   = 4'd4,
      PH_NAMLEN  = 4'd5,
      PH_NAMCH   = 4'd6,
      PH_DSCLEN  = 4'd7,
      PH_DSCCH   = 4'd8,
      PH_COUNT   = 4'd9,
      PH_TIME    = 4'd10,
      PH_PLAYTAG = 4'd11,
      PH_ELEN    = 4'd12,
      PH_ETYPE   = 4'd13,
      PH_EDATA   = 4'd14,
      PH_IGNORE  = 4'd15
   } phase_type;

   // Parse status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_MAGIC = 3'd1,
      ST_NO_INFO   = 3'd2,
      ST_NO_PLAY   = 3'd3,
      ST_TRUNC     = 3'd4
   } status_type;

   // File signature "to6o\0v1\0" and the two section tags
   localparam logic [BYTE_W-1:0] MAGIC_BYTES [MAGIC_LEN] =
      '{8'h74, 8'h6f, 8'h36, 8'h6f, 8'h00, 8'h76, 8'h31, 8'h00};
   localparam logic [BYTE_W-1:0] INFO_BYTES [TAG_LEN] =
      '{8'h49, 8'h4e, 8'h46, 8'h4f};
   localparam logic [BYTE_W-1:0] PLAY_BYTES [TAG_LEN] =
      '{8'h50, 8'h4c, 8'h41, 8'h59};

   // One input beat
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              is_last_byte;
   } req_item_type;

   // One result beat
   typedef struct packed {
      phase_type          field_kind;
      logic [BYTE_W-1:0]  field_byte;
      logic               field_end;
      logic [ENTRY_W-1:0] entry_number;
      status_type         parse_status;
   } rsp_item_type;

endpackage

FILE: rtl/core/plcbp_if.sv
// ----------------------------------------------------------------------------
// plcbp_if - valid/ready channels of the playlist byte parser
// Input byte channel and labelled result channel.
// ----------------------------------------------------------------------------
interface plcbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       is_last_byte;

   modport source (output valid, output byte_value, output is_last_byte, input ready);
   modport sink   (input valid, input byte_value, input is_last_byte, output ready);
endinterface

interface plcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_kind;
   logic [7:0]  field_byte;
   logic        field_end;
   logic [31:0] entry_number;
   logic [2:0]  parse_status;

   modport source (output valid, output field_kind, output field_byte, output field_end,
                   output entry_number, output parse_status, input ready);
   modport sink   (input valid, input field_kind, input field_byte, input field_end,
                   input entry_number, input parse_status, output ready);
endinterface

FILE: rtl/core/plcbp_in_stage.sv
// ----------------------------------------------------------------------------
// plcbp_in_stage - input register of the playlist byte parser
// Captures one byte beat and releases it when the result stage can take it.
// ----------------------------------------------------------------------------
module plcbp_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  plcbp_pkg::req_item_type in_item,
   input  logic                    out_free,
   output logic                    advance,
   output plcbp_pkg::req_item_type held_item
);

   logic                    valid_ff;
   logic                    valid_in;
   plcbp_pkg::req_item_type item_ff;

   // Move the held beat on whenever the result register is free
   assign advance   = valid_ff & out_free;
   assign in_ready  = ~valid_ff | advance;
   assign valid_in  = (in_valid & in_ready) | (valid_ff & ~advance);
   assign held_item = item_ff;

   // Hold the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on acceptance
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: rtl/core/plcbp_core.sv
// ----------------------------------------------------------------------------
// plcbp_core - parse state and byte labelling of the playlist byte parser
// Labels the held byte from the parse state and advances that state.
// ----------------------------------------------------------------------------
module plcbp_core #(
   parameter int unsigned ENTRY_COUNT_BITS = plcbp_pkg::ENTRY_COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  plcbp_pkg::req_item_type item,
   output plcbp_pkg::rsp_item_type result
);

   localparam int unsigned CW = plcbp_pkg::FIELD_CNT_W;

   plcbp_pkg::phase_type        phase_ff,   phase_in,   step_phase;
   logic [CW-1:0]               bif_ff,     bif_in,     step_bif;
   logic [CW-1:0]               flen_ff,    flen_in,    step_flen;
   logic                        match_ff,   match_in,   step_match;
   logic                        wide_ff,    wide_in,    step_wide;
   logic [ENTRY_COUNT_BITS-1:0] entries_ff, entries_in, step_entries;
   plcbp_pkg::status_type       status_ff,  status_in,  step_status;

   logic [CW:0]                 bif_inc;
   logic                        step_end;
   logic                        boundary;
   logic [7:0]                  b;
   logic [7:0]                  tag_byte;
   logic [CW:0]                 count_len;

   assign b        = item.byte_value;
   assign bif_inc  = {1'b0, bif_ff} + 1'b1;
   assign tag_byte = (phase_ff == plcbp_pkg::PH_INFOTAG) ?
                     plcbp_pkg::INFO_BYTES[bif_ff[1:0]] :
                     plcbp_pkg::PLAY_BYTES[bif_ff[1:0]];
   assign count_len = wide_ff ? (CW+1)'(plcbp_pkg::COUNT_LEN_WIDE) :
                                (CW+1)'(plcbp_pkg::COUNT_LEN_NARR);

   // Work out the state after this byte
   always_comb begin
      step_phase   = phase_ff;
      step_bif     = bif_ff;
      step_flen    = flen_ff;
      step_match   = match_ff;
      step_wide    = wide_ff;
      step_entries = entries_ff;
      step_status  = status_ff;
      step_end     = 1'b0;
      unique case (phase_ff)
         plcbp_pkg::PH_MAGIC: begin
            if (b != plcbp_pkg::MAGIC_BYTES[bif_ff[2:0]]) begin
               step_match = 1'b0;
            end
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= (CW+1)'(plcbp_pkg::MAGIC_LEN)) begin
               step_end   = 1'b1;
               step_bif   = '0;
               step_match = 1'b1;
               if (match_ff && b == plcbp_pkg::MAGIC_BYTES[bif_ff[2:0]]) begin
                  step_phase = plcbp_pkg::PH_INFOTAG;
               end else begin
                  step_status = plcbp_pkg::ST_BAD_MAGIC;
                  step_phase  = plcbp_pkg::PH_IGNORE;
               end
            end
         end
         plcbp_pkg::PH_INFOTAG, plcbp_pkg::PH_PLAYTAG: begin
            if (b != tag_byte) begin
               step_match = 1'b0;
            end
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= (CW+1)'(plcbp_pkg::TAG_LEN)) begin
               step_end   = 1'b1;
               step_bif   = '0;
               step_match = 1'b1;
               if (phase_ff == plcbp_pkg::PH_INFOTAG) begin
                  if (match_ff && b == tag_byte) begin
                     step_phase = plcbp_pkg::PH_FEAT;
                  end else begin
                     step_status = plcbp_pkg::ST_NO_INFO;
                     step_phase  = plcbp_pkg::PH_PLAYTAG;
                  end
               end else begin
                  if (match_ff && b == tag_byte) begin
                     step_phase = plcbp_pkg::PH_ELEN;
                  end else begin
                     step_status = plcbp_pkg::ST_NO_PLAY;
                     step_phase  = plcbp_pkg::PH_IGNORE;
                  end
               end
            end
         end
         plcbp_pkg::PH_FEAT: begin
            step_end   = 1'b1;
            step_wide  = ~b[0];
            step_phase = plcbp_pkg::PH_MAKLEN;
         end
         plcbp_pkg::PH_MAKLEN, plcbp_pkg::PH_NAMLEN, plcbp_pkg::PH_DSCLEN: begin
            // Length byte: go to the characters, or past them when empty
            step_end  = 1'b1;
            step_flen = CW'(b);
            step_bif  = '0;
            if (b == 8'd0) begin
               step_phase = plcbp_pkg::phase_type'(phase_ff + 4'd2);
            end else begin
               step_phase = plcbp_pkg::phase_type'(phase_ff + 4'd1);
            end
         end
         plcbp_pkg::PH_MAKCH, plcbp_pkg::PH_NAMCH, plcbp_pkg::PH_DSCCH: begin
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= {1'b0, flen_ff}) begin
               step_end   = 1'b1;
               step_bif   = '0;
               step_phase = plcbp_pkg::phase_type'(phase_ff + 4'd1);
            end
         end
         plcbp_pkg::PH_COUNT: begin
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= count_len) begin
               step_end   = 1'b1;
               step_bif   = '0;
               step_phase = plcbp_pkg::PH_TIME;
            end
         end
         plcbp_pkg::PH_TIME: begin
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= (CW+1)'(plcbp_pkg::TIME_LEN)) begin
               step_end   = 1'b1;
               step_bif   = '0;
               step_phase = plcbp_pkg::PH_PLAYTAG;
            end
         end
         plcbp_pkg::PH_ELEN: begin
            // Little-endian entry length: low byte first
            if (bif_ff == '0) begin
               step_flen = CW'(b);
               step_bif  = CW'(1);
            end else begin
               step_flen  = {b, flen_ff[7:0]};
               step_bif   = '0;
               step_end   = 1'b1;
               step_phase = plcbp_pkg::PH_ETYPE;
            end
         end
         plcbp_pkg::PH_ETYPE: begin
            step_end = 1'b1;
            step_bif = '0;
            if (flen_ff == '0) begin
               if (entries_ff != '1) begin
                  step_entries = entries_ff + 1'b1;
               end
               step_phase = plcbp_pkg::PH_ELEN;
               step_flen  = '0;
            end else begin
               step_phase = plcbp_pkg::PH_EDATA;
            end
         end
         plcbp_pkg::PH_EDATA: begin
            step_bif = bif_inc[CW-1:0];
            if (bif_inc >= {1'b0, flen_ff}) begin
               step_end = 1'b1;
               if (entries_ff != '1) begin
                  step_entries = entries_ff + 1'b1;
               end
               step_phase = plcbp_pkg::PH_ELEN;
               step_bif   = '0;
               step_flen  = '0;
            end
         end
         plcbp_pkg::PH_IGNORE: begin
            step_end = 1'b0;
         end
      endcase
   end

   // Flag a file that stops inside a field
   assign boundary = (step_phase == plcbp_pkg::PH_IGNORE) ||
                     (step_phase == plcbp_pkg::PH_ELEN && step_bif == '0);

   // Return to the start of a file after its last byte
   always_comb begin
      if (item.is_last_byte) begin
         phase_in   = plcbp_pkg::PH_MAGIC;
         bif_in     = '0;
         flen_in    = '0;
         match_in   = 1'b1;
         wide_in    = 1'b1;
         entries_in = '0;
         status_in  = plcbp_pkg::ST_OK;
      end else begin
         phase_in   = step_phase;
         bif_in     = step_bif;
         flen_in    = step_flen;
         match_in   = step_match;
         wide_in    = step_wide;
         entries_in = step_entries;
         status_in  = step_status;
      end
   end

   // Label the byte
   always_comb begin
      result.field_kind   = phase_ff;
      result.field_byte   = b;
      result.field_end    = step_end;
      result.entry_number = plcbp_pkg::ENTRY_W'(entries_ff);
      if (item.is_last_byte && !boundary) begin
         result.parse_status = plcbp_pkg::ST_TRUNC;
      end else begin
         result.parse_status = step_status;
      end
   end

   // Advance the parse state once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= plcbp_pkg::PH_MAGIC;
         bif_ff     <= '0;
         flen_ff    <= '0;
         match_ff   <= 1'b1;
         wide_ff    <= 1'b1;
         entries_ff <= '0;
         status_ff  <= plcbp_pkg::ST_OK;
      end else if (advance) begin
         phase_ff   <= phase_in;
         bif_ff     <= bif_in;
         flen_ff    <= flen_in;
         match_ff   <= match_in;
         wide_ff    <= wide_in;
         entries_ff <= entries_in;
         status_ff  <= status_in;
      end
   end

endmodule

FILE: rtl/core/plcbp_out_stage.sv
// ----------------------------------------------------------------------------
// plcbp_out_stage - result register of the playlist byte parser
// Holds one labelled beat until the receiver takes it.
// ----------------------------------------------------------------------------
module plcbp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  plcbp_pkg::rsp_item_type load_item,
   output logic                    free,
   output logic                    out_valid,
   input  logic                    out_ready,
   output plcbp_pkg::rsp_item_type out_item
);

   logic                    valid_ff;
   logic                    valid_in;
   plcbp_pkg::rsp_item_type item_ff;

   // Free when empty or when the held beat leaves this cycle
   assign free      = ~valid_ff | out_ready;
   assign valid_in  = load | (valid_ff & ~out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

FILE: rtl/core/playlist_container_byte_parser_unit.sv
// ----------------------------------------------------------------------------
// playlist_container_byte_parser_unit - playlist container byte labeller
// Takes a container file one byte per beat and labels every byte with
// the field it belongs to, the current entry index and the parse status.
//
// req_bus carries one file byte and an end-of-file flag per beat; rsp_bus
// returns exactly one labelled beat for each byte, in order.
// Each byte passes through the input register, then the result register,
// where the receiver takes its labelled beat. The parser takes one byte
// per cycle while the receiver does not stall; the parse state advances
// as each byte moves from the input register into the result register.
// A beat flagged as last closes the file; the next byte starts a new one.
// Reset empties both registers and puts the parser at the start of a file.
// When the receiver stalls, the result register holds its beat, the input
// register holds the next byte, and req_bus.ready drops once both are full.
// ----------------------------------------------------------------------------
module playlist_container_byte_parser_unit #(
   parameter int unsigned ENTRY_COUNT_BITS = plcbp_pkg::ENTRY_COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   plcbp_req_if.sink  req_bus,
   plcbp_rsp_if.source rsp_bus
);

   plcbp_pkg::req_item_type req_item;
   plcbp_pkg::req_item_type held_item;
   plcbp_pkg::rsp_item_type core_result;
   plcbp_pkg::rsp_item_type rsp_item;
   logic                    advance;
   logic                    out_free;

   assign req_item.byte_value   = req_bus.byte_value;
   assign req_item.is_last_byte = req_bus.is_last_byte;

   // Input register
   plcbp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_free  (out_free),
      .advance   (advance),
      .held_item (held_item)
   );

   // Parse state and labelling
   plcbp_core #(
      .ENTRY_COUNT_BITS (ENTRY_COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .result  (core_result)
   );

   // Result register
   plcbp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (core_result),
      .free      (out_free),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

   assign rsp_bus.field_kind   = rsp_item.field_kind;
   assign rsp_bus.field_byte   = rsp_item.field_byte;
   assign rsp_bus.field_end    = rsp_item.field_end;
   assign rsp_bus.entry_number = rsp_item.entry_number;
   assign rsp_bus.parse_status = rsp_item.parse_status;

endmodule

FILE: tb/plcbp_checker.sv
// ----------------------------------------------------------------------------
// plcbp_checker - result checker of the playlist byte parser
// Watches both channels. Every accepted input beat is run through a local
// model of the parser, and the labelled beat it yields is queued. Every
// accepted result beat is compared field by field with the oldest queued
// label. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module plcbp_checker
   import plcbp_pkg::*;
#(
   parameter int unsigned ENTRY_BITS = ENTRY_COUNT_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   plcbp_req_if  req_mon,
   plcbp_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    pending_count
);

   localparam logic [ENTRY_W-1:0] ENTRY_MAX =
      (ENTRY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ENTRY_BITS) - 32'd1);

   // Model state of the parser
   phase_type               phase;
   logic [FIELD_CNT_W-1:0]  pos;
   logic [FIELD_CNT_W-1:0]  flen;
   logic                    tag_ok;
   logic                    wide_count;
   logic [ENTRY_W-1:0]      entries;
   status_type              status;

   // Labels waiting for their result beat, oldest first
   rsp_item_type            label_q[$];
   int                      beat_index;

   task automatic clear_parser();
      phase      = PH_MAGIC;
      pos        = '0;
      flen       = '0;
      tag_ok     = 1'b1;
      wide_count = 1'b1;
      entries    = '0;
      status     = ST_OK;
   endtask

   // Close an entry: bump the saturating counter and wait for a new length
   task automatic close_entry();
      if (entries < ENTRY_MAX) begin
         entries = entries + 1'b1;
      end
      phase = PH_ELEN;
      pos   = '0;
      flen  = '0;
   endtask

   // Length byte of a short string: go to its characters, or skip them
   task automatic take_string_length(input logic [7:0] b, input phase_type char_ph,
                                     input phase_type next_ph);
      flen  = {8'h00, b};
      pos   = '0;
      phase = (b == 8'h00) ? next_ph : char_ph;
   endtask

   // Label one file byte and advance the model
   task automatic label_byte(input logic [7:0] b, input logic last,
                             output rsp_item_type lbl);
      phase_type          kind;
      logic [ENTRY_W-1:0] ent;
      logic               fin;
      logic [7:0]         tag_byte;
      kind = phase;
      ent  = entries;
      fin  = 1'b0;
      case (kind)
         PH_MAGIC: begin
            if (b != MAGIC_BYTES[pos[2:0]]) tag_ok = 1'b0;
            pos = pos + 1'b1;
            if (pos >= MAGIC_LEN) begin
               fin = 1'b1;
               pos = '0;
               if (tag_ok) begin
                  phase = PH_INFOTAG;
               end else begin
                  status = ST_BAD_MAGIC;
                  phase  = PH_IGNORE;
               end
               tag_ok = 1'b1;
            end
         end
         PH_INFOTAG, PH_PLAYTAG: begin
            tag_byte = (kind == PH_INFOTAG) ? INFO_BYTES[pos[1:0]] : PLAY_BYTES[pos[1:0]];
            if (b != tag_byte) tag_ok = 1'b0;
            pos = pos + 1'b1;
            if (pos >= TAG_LEN) begin
               fin = 1'b1;
               pos = '0;
               if (kind == PH_INFOTAG) begin
                  if (tag_ok) begin
                     phase = PH_FEAT;
                  end else begin
                     // no info section: the next four bytes are the play tag
                     status = ST_NO_INFO;
                     phase  = PH_PLAYTAG;
                  end
               end else begin
                  if (tag_ok) begin
                     phase = PH_ELEN;
                  end else begin
                     status = ST_NO_PLAY;
                     phase  = PH_IGNORE;
                  end
               end
               tag_ok = 1'b1;
            end
         end
         PH_FEAT: begin
            fin        = 1'b1;
            wide_count = ~b[0];
            phase      = PH_MAKLEN;
         end
         PH_MAKLEN: begin
            fin = 1'b1;
            take_string_length(b, PH_MAKCH, PH_NAMLEN);
         end
         PH_NAMLEN: begin
            fin = 1'b1;
            take_string_length(b, PH_NAMCH, PH_DSCLEN);
         end
         PH_DSCLEN: begin
            fin = 1'b1;
            take_string_length(b, PH_DSCCH, PH_COUNT);
         end
         PH_MAKCH, PH_NAMCH, PH_DSCCH: begin
            pos = pos + 1'b1;
            if (pos >= flen) begin
               fin = 1'b1;
               pos = '0;
               case (kind)
                  PH_MAKCH: phase = PH_NAMLEN;
                  PH_NAMCH: phase = PH_DSCLEN;
                  default:  phase = PH_COUNT;
               endcase
            end
         end
         PH_COUNT: begin
            pos = pos + 1'b1;
            if (pos >= (wide_count ? COUNT_LEN_WIDE : COUNT_LEN_NARR)) begin
               fin   = 1'b1;
               pos   = '0;
               phase = PH_TIME;
            end
         end
         PH_TIME: begin
            pos = pos + 1'b1;
            if (pos >= TIME_LEN) begin
               fin   = 1'b1;
               pos   = '0;
               phase = PH_PLAYTAG;
            end
         end
         PH_ELEN: begin
            // little-endian 16-bit length, low byte first
            if (pos == '0) begin
               flen = {8'h00, b};
               pos  = 16'd1;
            end else begin
               flen  = {b, flen[7:0]};
               pos   = '0;
               fin   = 1'b1;
               phase = PH_ETYPE;
            end
         end
         PH_ETYPE: begin
            fin = 1'b1;
            pos = '0;
            if (flen == '0) begin
               close_entry();
            end else begin
               phase = PH_EDATA;
            end
         end
         PH_EDATA: begin
            pos = pos + 1'b1;
            if (pos >= flen) begin
               fin = 1'b1;
               close_entry();
            end
         end
         default: begin
         end
      endcase

      // End of file away from an entry boundary means truncation
      if (last && !(phase == PH_IGNORE || (phase == PH_ELEN && pos == '0))) begin
         status = ST_TRUNC;
      end

      lbl.field_kind   = kind;
      lbl.field_byte   = b;
      lbl.field_end    = fin;
      lbl.entry_number = ent;
      lbl.parse_status = status;

      if (last) clear_parser();
   endtask

   task automatic report(input string msg);
      $display("%0t plcbp_checker: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("beat %0d %s: got %0h, expected %0h", beat_index, name, got, want));
      end
   endtask

   // Compare one result beat against the oldest queued label
   task automatic check_beat();
      rsp_item_type want;
      if (label_q.size() == 0) begin
         report($sformatf("result beat with no byte outstanding, byte %02h",
                          rsp_mon.field_byte));
         return;
      end
      want = label_q.pop_front();
      compare_field("field_kind", 32'(rsp_mon.field_kind), 32'(want.field_kind));
      compare_field("field_byte", 32'(rsp_mon.field_byte), 32'(want.field_byte));
      compare_field("field_end", 32'(rsp_mon.field_end), 32'(want.field_end));
      compare_field("entry_number", rsp_mon.entry_number, want.entry_number);
      compare_field("parse_status", 32'(rsp_mon.parse_status), 32'(want.parse_status));
      beat_index++;
   endtask

   // Check results before queueing new labels: a beat accepted at this edge
   // always belongs to an earlier byte
   always @(posedge clock) begin
      rsp_item_type lbl;
      if (reset) begin
         clear_parser();
         label_q.delete();
         mismatch_count = 0;
         beat_index     = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
         if (req_mon.valid && req_mon.ready) begin
            label_byte(req_mon.byte_value, req_mon.is_last_byte, lbl);
            label_q.push_back(lbl);
         end
      end
      pending_count = label_q.size();
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top of the playlist container byte parser
// Builds container files byte by byte (well-formed, truncated, with a bad
// signature or bad tags, and plain noise), feeds them through the parser
// with random gaps and receiver stalls, and gives the verdict from the
// mismatch count of the checker.
// ----------------------------------------------------------------------------
module tb;
   import plcbp_pkg::*;

   localparam int unsigned ENTRY_BITS  = ENTRY_COUNT_BITS_DEF;
   localparam int          ITEM_TARGET = 1950;
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          NO_FAULT    = -1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plcbp_req_if req_ch ();
   plcbp_rsp_if rsp_ch ();

   int errors;
   int pending;

   // File under construction and run bookkeeping
   logic [7:0] file_q[$];
   int         body_len;
   int         items_sent   = 0;
   bit         calm         = 1'b0;
   bit         hold_request = 1'b0;
   int         idle_cycles  = 0;

   playlist_container_byte_parser_unit #(
      .ENTRY_COUNT_BITS (ENTRY_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   plcbp_checker #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (errors),
      .pending_count  (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none during a calm stretch
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic int pick_string_len();
      if ($urandom_range(0, 99) < 3) return $urandom_range(0, 255);
      return $urandom_range(0, 6);
   endfunction

   function automatic int pick_entry_len();
      if ($urandom_range(0, 99) < 4) return $urandom_range(200, 700);
      return $urandom_range(0, 12);
   endfunction

   // Append the signature, with one byte spoilt at bad_at unless NO_FAULT
   task automatic push_magic(input int bad_at);
      for (int i = 0; i < MAGIC_LEN; i++) begin
         file_q.push_back(MAGIC_BYTES[i] ^ ((i == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00));
      end
   endtask

   task automatic push_tag(input bit play, input int bad_at);
      logic [7:0] t;
      for (int i = 0; i < TAG_LEN; i++) begin
         t = play ? PLAY_BYTES[i] : INFO_BYTES[i];
         file_q.push_back(t ^ ((i == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00));
      end
   endtask

   task automatic push_random(input int n);
      repeat (n) file_q.push_back(8'($urandom));
   endtask

   // Info section: feature byte, three strings, count and timestamp
   task automatic push_info(input logic [7:0] feat, input int l0, input int l1, input int l2);
      int lens[3];
      lens = '{l0, l1, l2};
      file_q.push_back(feat);
      foreach (lens[i]) begin
         file_q.push_back(8'(lens[i]));
         push_random(lens[i]);
      end
      push_random(feat[0] ? COUNT_LEN_NARR : COUNT_LEN_WIDE);
      push_random(TIME_LEN);
   endtask

   task automatic push_entry(input int len, input int ndata);
      file_q.push_back(8'(len));
      file_q.push_back(8'(len >> 8));
      file_q.push_back(8'($urandom));
      push_random(ndata);
   endtask

   // Offer one byte and hold it until the parser takes it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.byte_value   = b;
      req_ch.is_last_byte = last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send the file, cut after cut bytes when cut is positive
   task automatic send_file(input int cut);
      int n;
      n = (cut <= 0 || cut > file_q.size()) ? file_q.size() : cut;
      for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
      items_sent += (n < body_len) ? n : body_len;
   endtask

   // Receiver: random ready runs and stalls, plus one long hold-off
   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
            g = pick_gap();
            if (g > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int  pick;
      int  len;
      bit  bad_info;
      bit  bad_play;
      req_ch.valid        = 1'b0;
      req_ch.byte_value   = 8'h00;
      req_ch.is_last_byte = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Bad signature on its final byte, then ignored bytes
      file_q.delete();
      push_magic(MAGIC_LEN - 1);
      body_len = file_q.size();
      file_q.push_back(8'h00);
      file_q.push_back(8'hFF);
      send_file(0);

      // Missing info tag: straight on to the play tag and one entry
      file_q.delete();
      push_magic(NO_FAULT);
      push_tag(1'b0, 0);
      push_tag(1'b1, NO_FAULT);
      push_entry(1, 1);
      body_len = file_q.size();
      send_file(0);

      // Narrow count, empty strings, empty entry, longest entry cut short
      file_q.delete();
      push_magic(NO_FAULT);
      push_tag(1'b0, NO_FAULT);
      push_info(8'hFF, 0, 0, 0);
      push_tag(1'b1, NO_FAULT);
      push_entry(0, 0);
      push_entry(16'hFFFF, 2);
      body_len = file_q.size();
      send_file(0);

      // Missing info tag then missing play tag: the later code wins
      file_q.delete();
      push_magic(NO_FAULT);
      push_tag(1'b0, TAG_LEN - 1);
      push_tag(1'b1, 2);
      body_len = file_q.size();
      file_q.push_back(8'h5A);
      send_file(0);

      // Wide count, non-empty strings, file ends right after the play tag
      file_q.delete();
      push_magic(NO_FAULT);
      push_tag(1'b0, NO_FAULT);
      push_info(8'h00, 1, 2, 3);
      push_tag(1'b1, NO_FAULT);
      body_len = file_q.size();
      send_file(0);

      // A lone last byte: truncated inside the signature
      file_q.delete();
      file_q.push_back(8'hFF);
      body_len = 1;
      send_file(0);

      // Random files; the receiver holds off once early on
      hold_request = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         file_q.delete();
         if (pick >= 95) begin
            push_random($urandom_range(1, 40));
            body_len = file_q.size();
            send_file(0);
         end else if (pick >= 75 && pick < 82) begin
            push_magic($urandom_range(0, MAGIC_LEN - 1));
            body_len = file_q.size();
            push_random($urandom_range(0, 10));
            send_file(0);
         end else begin
            bad_info = (pick >= 82 && pick < 89);
            bad_play = (pick >= 89);
            push_magic(NO_FAULT);
            push_tag(1'b0, bad_info ? $urandom_range(0, TAG_LEN - 1) : NO_FAULT);
            if (!bad_info) begin
               push_info(8'($urandom), pick_string_len(), pick_string_len(),
                         pick_string_len());
            end
            push_tag(1'b1, bad_play ? $urandom_range(0, TAG_LEN - 1) : NO_FAULT);
            if (bad_play) begin
               body_len = file_q.size();
               push_random($urandom_range(0, 10));
               send_file(0);
            end else begin
               repeat ($urandom_range(0, 6)) begin
                  len = pick_entry_len();
                  push_entry(len, len);
               end
               body_len = file_q.size();
               send_file((pick >= 60) ? $urandom_range(1, file_q.size()) : 0);
            end
         end
      end
      calm         = 1'b0;
      req_ch.valid = 1'b0;

      // Drain outstanding results, then allow for the pipeline latency
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/plcbp_pkg.sv
rtl/core/plcbp_if.sv
rtl/core/plcbp_in_stage.sv
rtl/core/plcbp_core.sv
rtl/core/plcbp_out_stage.sv
rtl/core/playlist_container_byte_parser_unit.sv
tb/plcbp_checker.sv
tb/tb.sv
